// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the block averager.
// Needs a signal named clk, and arst_n for MBA_ASSERT, in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define MBA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MBA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/mba_pkg.sv
// Shared constants, types and register codes of the block averager.
// No dependencies; every file but assert_macros.svh uses this package.
package mba_pkg;

	localparam int CHANNELS = 5;
	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 22;
	localparam int LEN_W    = 10;
	localparam int DIV_W    = LEN_W + 1;  // divisor reaches 1024
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STEP_W   = $clog2(SUM_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [SAMPLE_W-1:0] AVG_MAX          = '1;
	localparam logic [LEN_W-1:0]    BLOCK_LENGTH_RST = 10'd50;
	localparam logic [SAMPLE_W-1:0] SATURATION_RST   = 12'd3200;

	typedef enum logic {
		REG_BLOCK_LENGTH     = 1'b0,
		REG_SATURATION_LEVEL = 1'b1
	} reg_idx_t;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SUM_W-1:0]    sum_t;

	// One finished block waiting for division.
	typedef struct packed {
		sum_t [CHANNELS-1:0] sums;
		logic [DIV_W-1:0]    divisor;
		sample_t             sat_level;
	} job_t;

	typedef struct packed {
		sample_t [CHANNELS-1:0] avg;
		logic [CHANNELS-1:0]    mask;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// File: sv/mba_in_if.sv
// Input channel of the block averager: one scan of samples per item.
// Depends on mba_pkg.
interface mba_in_if;
	logic             valid;
	logic             ready;
	mba_pkg::sample_t sample_0;
	mba_pkg::sample_t sample_1;
	mba_pkg::sample_t sample_2;
	mba_pkg::sample_t sample_3;
	mba_pkg::sample_t sample_4;

	modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		input ready);
	modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		output ready);
endinterface

// File: sv/mba_out_if.sv
// Result channel of the block averager: per-channel averages and saturation mask.
// Depends on mba_pkg.
interface mba_out_if;
	logic                          valid;
	logic                          ready;
	mba_pkg::sample_t              average_0;
	mba_pkg::sample_t              average_1;
	mba_pkg::sample_t              average_2;
	mba_pkg::sample_t              average_3;
	mba_pkg::sample_t              average_4;
	logic [mba_pkg::CHANNELS-1:0]  saturated_mask;

	modport source (output valid, average_0, average_1, average_2, average_3, average_4,
		saturated_mask, input ready);
	modport sink (input valid, average_0, average_1, average_2, average_3, average_4,
		saturated_mask, output ready);
endinterface

// File: sv/multichannel_block_averager.sv
// Top level of the multichannel block averager: register port, scan front
// end, job queue and shared divider. Depends on mba_pkg, mba_in_if, mba_out_if.
//
// Use: each item on in_ch is one scan of five 12-bit samples. Scans are summed
// per channel; when the scan count reaches block_length (0 means 1024) one
// result leaves on out_ch: five truncated averages, clamped to 4095, and a
// mask bit per channel set where the average is >= saturation_level.
// Scans that do not close a block produce nothing.
// Throughput: scans are taken one per cycle while in_ch.ready is high. The
// divider handles each closed block channel by channel, one quotient bit a
// cycle. Path: the closing scan's job enters the job queue, the idle divider
// pops and divides it, then loads the output register. The two-entry queue
// holds closed blocks while the divider works, so in_ch.ready drops only
// when two closed blocks are waiting. Stall: a result waits in the output
// register until out_ch.ready; the front end sums on until the queue fills.
// Reset (arst_n low): sums and count cleared, block_length = 50,
// saturation_level = 3200, no result pending.
// Registers: 0x0 block_length [9:0], 0x4 saturation_level [11:0]; writes
// leave the running sums untouched.
module multichannel_block_averager (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mba_pkg::PADDR_W-1:0]  paddr,
	input  logic [mba_pkg::PDATA_W-1:0]  pwdata,
	output logic [mba_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	mba_in_if.sink                       in_ch,
	mba_out_if.source                    out_ch
);
	import mba_pkg::*;

	logic [LEN_W-1:0]       block_length_q;
	sample_t                saturation_level_q;
	logic                   cfg_write;
	reg_idx_t               reg_idx;
	sample_t [CHANNELS-1:0] samples;
	logic                   push;
	job_t                   push_job;
	logic                   pop;
	job_t                   head;
	queue_status_t          qstat;
	result_t                result;

	// Register port: no wait states, word address selects the register.
	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[PADDR_W-1]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q     <= BLOCK_LENGTH_RST;
			saturation_level_q <= SATURATION_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_BLOCK_LENGTH:     block_length_q     <= pwdata[LEN_W-1:0];
				REG_SATURATION_LEVEL: saturation_level_q <= pwdata[SAMPLE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BLOCK_LENGTH:     prdata = PDATA_W'(block_length_q);
			REG_SATURATION_LEVEL: prdata = PDATA_W'(saturation_level_q);
		endcase
	end

	assign samples[0] = in_ch.sample_0;
	assign samples[1] = in_ch.sample_1;
	assign samples[2] = in_ch.sample_2;
	assign samples[3] = in_ch.sample_3;
	assign samples[4] = in_ch.sample_4;

	mba_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.samples      (samples),
		.block_length (block_length_q),
		.sat_level    (saturation_level_q),
		.qstat        (qstat),
		.push         (push),
		.push_job     (push_job)
	);

	mba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (qstat)
	);

	mba_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_result (result)
	);

	assign out_ch.average_0      = result.avg[0];
	assign out_ch.average_1      = result.avg[1];
	assign out_ch.average_2      = result.avg[2];
	assign out_ch.average_3      = result.avg[3];
	assign out_ch.average_4      = result.avg[4];
	assign out_ch.saturated_mask = result.mask;

endmodule

// File: sv/mba_front.sv
// Front end: accepts scans, keeps running sums and the scan count, and posts
// a finished block to the job queue. Depends on mba_pkg.
module mba_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  mba_pkg::sample_t [mba_pkg::CHANNELS-1:0] samples,
	input  logic [mba_pkg::LEN_W-1:0]              block_length,
	input  mba_pkg::sample_t                       sat_level,
	input  mba_pkg::queue_status_t                 qstat,
	output logic                                   push,
	output mba_pkg::job_t                          push_job
);
	import mba_pkg::*;

	sum_t [CHANNELS-1:0] sums_q;
	sum_t [CHANNELS-1:0] sums_next;
	logic [LEN_W-1:0]    count_q;
	logic [DIV_W-1:0]    len;
	logic [DIV_W-1:0]    next_count;
	logic                accept;
	logic                block_done;

	// Back pressure only when the queue has no free slot.
	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		// zero length means 1024 scans
		len = (block_length == '0) ? {1'b1, {LEN_W{1'b0}}} : {1'b0, block_length};
		next_count = DIV_W'(count_q) + DIV_W'(1);
		for (int k = 0; k < CHANNELS; k++) begin
			sums_next[k] = sums_q[k] + SUM_W'(samples[k]);
		end
		// >= so that a length lowered mid-block ends it on the next scan
		block_done = (next_count >= len);
	end

	assign push             = accept && block_done;
	assign push_job.sums      = sums_next;
	assign push_job.divisor   = len;
	assign push_job.sat_level = sat_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (block_done) begin
				sums_q  <= '0;
				count_q <= '0;
			end else begin
				sums_q  <= sums_next;
				count_q <= next_count[LEN_W-1:0];
			end
		end
	end

endmodule

// File: sv/mba_queue.sv
// Short job queue between the accumulating front end and the divider.
// Depends on mba_pkg.
module mba_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mba_pkg::job_t          push_job,
	input  logic                   pop,
	output mba_pkg::job_t          head,
	output mba_pkg::queue_status_t status
);
	import mba_pkg::*;

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head         = slot_q[rd_ptr_q];
	assign status.full  = (fill_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign status.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + (PTR_W + 1)'(1);
				2'b01:   fill_q <= fill_q - (PTR_W + 1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// File: sv/mba_back.sv
// Back end: restoring divider, one quotient bit per cycle, shared by all
// channels in turn; clamps, builds the mask and holds the result register.
// Depends on mba_pkg.
module mba_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mba_pkg::queue_status_t qstat,
	input  mba_pkg::job_t          head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mba_pkg::result_t       out_result
);
	import mba_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_DIVIDE  = 3'b010,
		ST_DELIVER = 3'b100
	} state_t;

	state_t                 state_q;
	job_t                   job_q;
	logic [CH_W-1:0]        ch_q;
	logic [CH_W-1:0]        ch_next;
	logic [STEP_W-1:0]      step_q;
	logic [DIV_W-1:0]       rem_q;
	sum_t                   quo_q;
	sample_t [CHANNELS-1:0] avg_q;
	logic [CHANNELS-1:0]    mask_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic [DIV_W:0]   rem_shift;
	logic [DIV_W:0]   rem_sub;
	logic             fits;
	logic [DIV_W-1:0] rem_next;
	sum_t             quo_next;
	sample_t          avg_clamped;
	logic             last_step;
	logic             last_ch;
	logic             out_free;
	logic             load_out;

	always_comb begin
		rem_shift = {rem_q, quo_q[SUM_W-1]};
		rem_sub   = rem_shift - {1'b0, job_q.divisor};
		fits      = (rem_shift >= {1'b0, job_q.divisor});
		// remainder stays below the divisor, so DIV_W bits hold it
		rem_next  = fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
		quo_next  = {quo_q[SUM_W-2:0], fits};
		avg_clamped = (|quo_next[SUM_W-1:SAMPLE_W]) ? AVG_MAX : quo_next[SAMPLE_W-1:0];
		last_step = (step_q == STEP_W'(SUM_W - 1));
		last_ch   = (ch_q == CH_W'(CHANNELS - 1));
		ch_next   = ch_q + CH_W'(1);
	end

	assign pop        = (state_q == ST_IDLE) && !qstat.empty;
	assign out_free   = !out_valid_q || out_ready;
	assign load_out   = (state_q == ST_DELIVER) && out_free;
	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						ch_q    <= '0;
						step_q  <= '0;
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (last_step) begin
						step_q <= '0;
						if (last_ch) begin
							state_q <= ST_DELIVER;
						end else begin
							ch_q <= ch_next;
						end
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_DELIVER: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					job_q <= head;
					rem_q <= '0;
					quo_q <= head.sums[0];
				end
			end
			ST_DIVIDE: begin
				if (last_step) begin
					avg_q[ch_q]  <= avg_clamped;
					mask_q[ch_q] <= (avg_clamped >= job_q.sat_level);
					rem_q        <= '0;
					quo_q        <= job_q.sums[ch_next];
				end else begin
					rem_q <= rem_next;
					quo_q <= quo_next;
				end
			end
			ST_DELIVER: begin
				if (out_free) begin
					out_q.avg  <= avg_q;
					out_q.mask <= mask_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: sv/mba_assert_chk.sv
// Port-level checks of the block averager, bound to the top level.
// Depends on assert_macros.svh and mba_pkg.
`include "assert_macros.svh"

module mba_assert_chk (
	input logic                                                clk,
	input logic                                                arst_n,
	input logic                                                psel,
	input logic                                                penable,
	input logic                                                pwrite,
	input logic [mba_pkg::PADDR_W-1:0]                         paddr,
	input logic [mba_pkg::PDATA_W-1:0]                         pwdata,
	input logic [mba_pkg::PDATA_W-1:0]                         prdata,
	input logic                                                pready,
	input logic                                                out_valid,
	input logic                                                out_ready,
	input logic [mba_pkg::CHANNELS*(mba_pkg::SAMPLE_W+1)-1:0]  out_data
);
	import mba_pkg::*;

	logic len_write;

	assign len_write = psel && penable && pwrite && pready &&
		(paddr[PADDR_W-1] == REG_BLOCK_LENGTH);

	`MBA_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !out_valid, "result valid in reset")

	`MBA_ASSERT_ALWAYS(a_pready_high, pready, "pready low")

	`MBA_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

	`MBA_ASSERT(a_len_readback, $past(arst_n) && $past(len_write) && (paddr[PADDR_W-1] == REG_BLOCK_LENGTH) |-> prdata == PDATA_W'($past(pwdata[LEN_W-1:0])), "block_length readback wrong")

endmodule

bind multichannel_block_averager mba_assert_chk u_mba_assert (
	.clk       (clk),
	.arst_n    (arst_n),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.pready    (pready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  ({out_ch.average_0, out_ch.average_1, out_ch.average_2, out_ch.average_3,
		out_ch.average_4, out_ch.saturated_mask})
);
